// ----- src/svpc_pkg.sv -----
`timescale 1ns / 1ps
// Package for the servo position command unit: codes, constants, the
// microcode table and the control structs shared by the sequencer and datapath.
// No dependencies.
package svpc_pkg;

    // Serial divider sizes: dividend magnitude up to 180 * 4095.
    localparam int DVD_W = 20;
    localparam int DEN_W = 12;
    localparam int CNT_W = 5;
    localparam int NUM_W = DVD_W + 1;
    localparam int UPC_W = 3;

    // Reset values of the configuration registers and the position.
    localparam logic [11:0] MIN_RST   = 12'd1000;
    localparam logic [11:0] MAX_RST   = 12'd2000;
    localparam logic [9:0]  STEP_RST  = 10'd10;
    localparam logic [11:0] HOME_RST  = 12'd1500;
    localparam logic [11:0] PULSE_RST = 12'd1500;

    // Fixed limits.
    localparam logic [11:0] PULSE_LO   = 12'd500;
    localparam logic [11:0] PULSE_HI   = 12'd2500;
    localparam logic [7:0]  DEG_MAX    = 8'd180;
    localparam logic [7:0]  DEG_CENTER = 8'd90;

    // Command codes.
    typedef enum logic [2:0] {
        FN_SET_DEG  = 3'd0,
        FN_SET_US   = 3'd1,
        FN_ADD_DEG  = 3'd2,
        FN_ADD_US   = 3'd3,
        FN_STEP_CCW = 3'd4,
        FN_STEP_CW  = 3'd5,
        FN_HOME     = 3'd6,
        FN_CENTER   = 3'd7
    } func_t;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_MIN_PULSE = 3'd0,
        CFG_MAX_PULSE = 3'd1,
        CFG_STEP      = 3'd2,
        CFG_HOME      = 3'd3
    } cfg_idx_t;

    // Datapath operations, one per control word.
    typedef enum logic [2:0] {
        OP_FETCH    = 3'd0,
        OP_ARG      = 3'd1,
        OP_ANGLE    = 3'd2,
        OP_PULSE    = 3'd3,
        OP_DIV_INIT = 3'd4,
        OP_DIV_STEP = 3'd5,
        OP_DIV_FIX  = 3'd6,
        OP_COMMIT   = 3'd7
    } op_t;

    // Jump conditions.
    typedef enum logic [2:0] {
        JC_NONE      = 3'd0,
        JC_ALWAYS    = 3'd1,
        JC_NO_REQ    = 3'd2,
        JC_PULSE_CMD = 3'd3,
        JC_SPAN_ZERO = 3'd4,
        JC_DIV_MORE  = 3'd5,
        JC_OUT_BUSY  = 3'd6
    } jc_t;

    // Program addresses.
    localparam logic [UPC_W-1:0] A_FETCH    = 3'd0;
    localparam logic [UPC_W-1:0] A_ARG      = 3'd1;
    localparam logic [UPC_W-1:0] A_ANGLE    = 3'd2;
    localparam logic [UPC_W-1:0] A_PULSE    = 3'd3;
    localparam logic [UPC_W-1:0] A_DIV_INIT = 3'd4;
    localparam logic [UPC_W-1:0] A_DIV_STEP = 3'd5;
    localparam logic [UPC_W-1:0] A_DIV_FIX  = 3'd6;
    localparam logic [UPC_W-1:0] A_COMMIT   = 3'd7;

    typedef struct packed {
        op_t              op;
        jc_t              jc;
        logic [UPC_W-1:0] target;
    } ucode_t;

    // Status flags that the sequencer tests.
    typedef struct packed {
        logic in_req;
        logic pulse_cmd;
        logic span_zero;
        logic div_more;
        logic out_busy;
    } seq_status_t;

    // Control that the sequencer hands to the datapath.
    typedef struct packed {
        op_t              op;
        logic             jump;
        logic [UPC_W-1:0] upc;
    } seq_ctrl_t;

    // The program. The commit step falls through to fetch by wrapping.
    function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] addr);
        ucode_t w;
        case (addr)
            A_FETCH:    w = '{op: OP_FETCH,    jc: JC_NO_REQ,    target: A_FETCH};
            A_ARG:      w = '{op: OP_ARG,      jc: JC_PULSE_CMD, target: A_PULSE};
            A_ANGLE:    w = '{op: OP_ANGLE,    jc: JC_ALWAYS,    target: A_DIV_INIT};
            A_PULSE:    w = '{op: OP_PULSE,    jc: JC_SPAN_ZERO, target: A_COMMIT};
            A_DIV_INIT: w = '{op: OP_DIV_INIT, jc: JC_NONE,      target: A_FETCH};
            A_DIV_STEP: w = '{op: OP_DIV_STEP, jc: JC_DIV_MORE,  target: A_DIV_STEP};
            A_DIV_FIX:  w = '{op: OP_DIV_FIX,  jc: JC_NONE,      target: A_FETCH};
            A_COMMIT:   w = '{op: OP_COMMIT,   jc: JC_OUT_BUSY,  target: A_COMMIT};
            default:    w = '{op: OP_FETCH,    jc: JC_ALWAYS,    target: A_FETCH};
        endcase
        return w;
    endfunction

endpackage

// ----- src/svpc_seq.sv -----
`timescale 1ns / 1ps
// Microcode sequencer: step counter, control word lookup and conditional jumps.
// Depends on svpc_pkg.
module svpc_seq
    import svpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  seq_status_t status,
    output seq_ctrl_t   ctrl
);

    logic [UPC_W-1:0] upc_reg;
    logic [UPC_W-1:0] upc_next;
    ucode_t           word;
    logic             jump;

    // Fetch the control word of the current step.
    assign word = ucode_rom(upc_reg);

    // Evaluate the jump condition.
    always_comb
    begin
        case (word.jc)
            JC_NONE:      jump = 1'b0;
            JC_ALWAYS:    jump = 1'b1;
            JC_NO_REQ:    jump = !status.in_req;
            JC_PULSE_CMD: jump = status.pulse_cmd;
            JC_SPAN_ZERO: jump = status.span_zero;
            JC_DIV_MORE:  jump = status.div_more;
            JC_OUT_BUSY:  jump = status.out_busy;
            default:      jump = 1'b1;
        endcase
        upc_next = jump ? word.target : upc_reg + 1'b1;
    end

    // Step counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= A_FETCH;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

    assign ctrl = '{op: word.op, jump: jump, upc: upc_reg};

endmodule

// ----- src/svpc_div.sv -----
`timescale 1ns / 1ps
// Serial restoring divider, one quotient bit per step, with sign applied
// at the end. Depends on svpc_pkg.
module svpc_div
    import svpc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic                    step,
    input  logic [DVD_W-1:0]        dividend,
    input  logic [DEN_W-1:0]        divisor,
    input  logic                    neg,
    output logic signed [NUM_W-1:0] quotient,
    output logic                    more
);

    logic [DVD_W-1:0] quo_reg;
    logic [DVD_W-1:0] quo_next;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] rem_next;
    logic [DEN_W-1:0] den_reg;
    logic             neg_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W:0]   shifted;
    logic             fits;

    // One restoring iteration.
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[DVD_W-1]};
        fits     = shifted >= {1'b0, den_reg};
        rem_next = fits ? DEN_W'(shifted - {1'b0, den_reg}) : shifted[DEN_W-1:0];
        quo_next = {quo_reg[DVD_W-2:0], fits};
    end

    // Operand and partial result registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
            neg_reg <= neg;
        end
        else if (step)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    // Iteration counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= '0;
        end
        else if (step && more)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    assign more = cnt_reg != CNT_W'(DVD_W - 1);

    // Quotient truncated toward zero.
    assign quotient = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});

endmodule

// ----- src/svpc_datapath.sv -----
`timescale 1ns / 1ps
// Datapath of the servo position command unit: configuration registers,
// position state, argument and clamp logic, output register. Depends on
// svpc_pkg and svpc_div.
module svpc_datapath
    import svpc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [11:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         func,
    input  logic signed [12:0] amount,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [11:0]        pulse_us,
    output logic [7:0]         angle_deg,
    input  seq_ctrl_t          ctrl,
    output seq_status_t        status
);

    logic [11:0]              min_reg;
    logic [11:0]              max_reg;
    logic [9:0]               step_reg;
    logic [11:0]              home_reg;
    logic [11:0]              cur_pulse_reg;
    logic [7:0]               cur_angle_reg;
    logic [2:0]               func_reg;
    logic signed [12:0]       amt_reg;
    logic signed [14:0]       x_reg;
    logic [11:0]              pulse_new_reg;
    logic [7:0]               angle_new_reg;
    logic signed [NUM_W-1:0]  num_reg;
    logic [DEN_W-1:0]         den_reg;
    logic                     den_neg_reg;
    logic                     mode_angle_reg;
    logic                     out_valid_reg;
    logic [11:0]              out_pulse_reg;
    logic [7:0]               out_angle_reg;

    logic                     accept;
    logic                     commit;
    logic signed [14:0]       arg;
    logic signed [14:0]       amt_x;
    logic signed [12:0]       span;
    logic [DEN_W-1:0]         span_mag;
    logic [7:0]               deg_clamp;
    logic [11:0]              pulse_pick;
    logic [12:0]              mid_sum;
    logic signed [12:0]       pulse_diff;
    logic signed [21:0]       prod_angle;
    logic signed [21:0]       prod_pulse;
    logic [DVD_W-1:0]         num_mag;
    logic signed [NUM_W-1:0]  quotient;
    logic [7:0]               quo_clamp;
    logic                     div_more;
    logic                     pulse_cmd;

    assign accept = (ctrl.op == OP_FETCH) && in_valid;
    assign commit = (ctrl.op == OP_COMMIT) && !ctrl.jump;
    assign in_stall = ctrl.op != OP_FETCH;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg  <= MIN_RST;
            max_reg  <= MAX_RST;
            step_reg <= STEP_RST;
            home_reg <= HOME_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MIN_PULSE: min_reg  <= cfg_data;
                CFG_MAX_PULSE: max_reg  <= cfg_data;
                CFG_STEP:      step_reg <= cfg_data[9:0];
                CFG_HOME:      home_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Command argument: a degree or a microsecond value.
    always_comb
    begin
        amt_x = {{2{amt_reg[12]}}, amt_reg};
        case (func_reg)
            FN_SET_DEG:  arg = amt_x;
            FN_SET_US:   arg = amt_x;
            FN_ADD_DEG:  arg = $signed({7'b0, cur_angle_reg}) + amt_x;
            FN_ADD_US:   arg = $signed({3'b0, cur_pulse_reg}) + amt_x;
            FN_STEP_CCW: arg = $signed({3'b0, cur_pulse_reg}) + $signed({5'b0, step_reg});
            FN_STEP_CW:  arg = $signed({3'b0, cur_pulse_reg}) - $signed({5'b0, step_reg});
            FN_HOME:     arg = $signed({3'b0, home_reg});
            default:     arg = $signed({7'b0, DEG_CENTER});
        endcase
    end

    always_comb
    begin
        case (func_reg) inside
            FN_SET_US, FN_ADD_US, FN_STEP_CCW, FN_STEP_CW, FN_HOME: pulse_cmd = 1'b1;
            default:                                                pulse_cmd = 1'b0;
        endcase
    end

    // Span and angle clamp.
    always_comb
    begin
        span     = $signed({1'b0, max_reg}) - $signed({1'b0, min_reg});
        span_mag = span[12] ? (~span[11:0] + 12'd1) : span[11:0];
        if (x_reg < 15'sd0)
        begin
            deg_clamp = 8'd0;
        end
        else if (x_reg > $signed({7'b0, DEG_MAX}))
        begin
            deg_clamp = DEG_MAX;
        end
        else
        begin
            deg_clamp = x_reg[7:0];
        end
        prod_angle = $signed({1'b0, deg_clamp}) * span;
    end

    // Pulse selection: clamp, switch off, or resume at the midpoint.
    always_comb
    begin
        mid_sum = {1'b0, min_reg} + {1'b0, max_reg};
        if (x_reg != 15'sd0)
        begin
            if (x_reg < $signed({3'b0, PULSE_LO}))
            begin
                pulse_pick = PULSE_LO;
            end
            else if (x_reg > $signed({3'b0, PULSE_HI}))
            begin
                pulse_pick = PULSE_HI;
            end
            else
            begin
                pulse_pick = x_reg[11:0];
            end
        end
        else if (cur_pulse_reg == 12'd0)
        begin
            pulse_pick = mid_sum[12:1];
        end
        else
        begin
            pulse_pick = 12'd0;
        end
        pulse_diff = $signed({1'b0, pulse_pick}) - $signed({1'b0, min_reg});
        prod_pulse = pulse_diff * $signed({1'b0, DEG_MAX});
    end

    // Divider operands and the saturated angle of a quotient.
    always_comb
    begin
        num_mag = num_reg[NUM_W-1] ? (~num_reg[DVD_W-1:0] + 1'b1) : num_reg[DVD_W-1:0];
        if (quotient < 0)
        begin
            quo_clamp = 8'd0;
        end
        else if (quotient > $signed({13'b0, DEG_MAX}))
        begin
            quo_clamp = DEG_MAX;
        end
        else
        begin
            quo_clamp = quotient[7:0];
        end
    end

    svpc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctrl.op == OP_DIV_INIT),
        .step     (ctrl.op == OP_DIV_STEP),
        .dividend (num_mag),
        .divisor  (den_reg),
        .neg      (num_reg[NUM_W-1] ^ den_neg_reg),
        .quotient (quotient),
        .more     (div_more)
    );

    // Working registers driven by the control word.
    always_ff @(posedge clk)
    begin
        case (ctrl.op)
            OP_FETCH:
            begin
                if (accept)
                begin
                    func_reg <= func;
                    amt_reg  <= amount;
                end
            end
            OP_ARG:
            begin
                x_reg <= arg;
            end
            OP_ANGLE:
            begin
                angle_new_reg  <= deg_clamp;
                num_reg        <= prod_angle[NUM_W-1:0];
                den_reg        <= {4'b0, DEG_MAX};
                den_neg_reg    <= 1'b0;
                mode_angle_reg <= 1'b1;
            end
            OP_PULSE:
            begin
                pulse_new_reg  <= pulse_pick;
                angle_new_reg  <= 8'd0;
                num_reg        <= prod_pulse[NUM_W-1:0];
                den_reg        <= span_mag;
                den_neg_reg    <= span[12];
                mode_angle_reg <= 1'b0;
            end
            OP_DIV_FIX:
            begin
                if (mode_angle_reg)
                begin
                    pulse_new_reg <= min_reg + quotient[11:0];
                end
                else
                begin
                    angle_new_reg <= quo_clamp;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Position state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_pulse_reg <= PULSE_RST;
            cur_angle_reg <= DEG_CENTER;
        end
        else if (commit)
        begin
            cur_pulse_reg <= pulse_new_reg;
            cur_angle_reg <= angle_new_reg;
        end
    end

    // Output register: holds a result until it is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            out_pulse_reg <= pulse_new_reg;
            out_angle_reg <= angle_new_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign pulse_us  = out_pulse_reg;
    assign angle_deg = out_angle_reg;

    assign status = '{in_req:    in_valid,
                      pulse_cmd: pulse_cmd,
                      span_zero: span == 13'sd0,
                      div_more:  div_more,
                      out_busy:  out_valid_reg && out_stall};

endmodule

// ----- src/servo_position_command_unit.sv -----
`timescale 1ns / 1ps
// Sequence: fetch, argument, angle or pulse, divider load, 20 divider steps,
// fix-up and commit. A pulse request with zero span skips the divider.
// A new request is taken only at fetch, after the last one has committed, and
// the commit step waits while the previous result is still held.
// Reset: asynchronous, active low; registers return to 1000, 2000, 10, 1500 us,
// the position to 1500 us at 90 degrees, and no result is pending.
module servo_position_command_unit
    import svpc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [11:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         func,
    input  logic signed [12:0] amount,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [11:0]        pulse_us,
    output logic [7:0]         angle_deg
);

    seq_ctrl_t   ctrl;
    seq_status_t status;

    // Microcode sequencer.
    svpc_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    // Datapath.
    svpc_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .amount    (amount),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .pulse_us  (pulse_us),
        .angle_deg (angle_deg),
        .ctrl      (ctrl),
        .status    (status)
    );

`ifndef SYNTH
    // An accepted request blocks further requests until it is done.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("request accepted while another is in progress");

    // A delivered angle is always saturated.
    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (angle_deg <= DEG_MAX))
        else $error("angle out of range");

    // The commit step waits while the previous result is still held.
    a_commit_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == OP_COMMIT && out_valid && out_stall) |=> (ctrl.op == OP_COMMIT))
        else $error("commit overran a pending result");

    // A result appears only from the commit step.
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(ctrl.op == OP_COMMIT))
        else $error("result raised outside the commit step");
`endif

endmodule
